/* rtl/vss_pkg.sv */
// ----------------------------------------------------------------------------
// Vibration synthesizer package
// Shared types, register map, fixed-point constants and small helper
// functions for the vibration signal synthesizer.
// ----------------------------------------------------------------------------
package vss_pkg;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_GAIN_MUL,
      ST_GAIN_WR,
      ST_SIN_R,
      ST_MUL_R,
      ST_MUL_R2,
      ST_MUL_H,
      ST_ADD_H,
      ST_STD,
      ST_N_DRAW,
      ST_N_MUL,
      ST_N_ADD,
      ST_F_START,
      ST_F_IMB_MUL,
      ST_F_IMB_ADD,
      ST_F_MIS_MUL2,
      ST_F_MIS_ADD2,
      ST_F_MIS_MUL3,
      ST_F_MIS_ADD3,
      ST_F_B_QUOT,
      ST_F_B_FIX,
      ST_F_B_MUL,
      ST_F_B_ADD,
      ST_F_BN_COEF,
      ST_F_BN_STD,
      ST_X_START,
      ST_X_SCALE,
      ST_X_GAIN,
      ST_X_OUT,
      ST_DONE
   } state_type;

   // Where a finished Gaussian draw is added and where the sequencer resumes.
   typedef enum logic [1:0] {
      GCTX_SAMPLE,
      GCTX_BEAR,
      GCTX_AXIS
   } gctx_type;

   localparam logic [2:0] REG_SEED      = 3'd0;
   localparam logic [2:0] REG_ROT_STEP  = 3'd1;
   localparam logic [2:0] REG_HUM_STEP  = 3'd2;
   localparam logic [2:0] REG_LOAD      = 3'd3;
   localparam logic [2:0] REG_FAULT     = 3'd4;
   localparam logic [2:0] REG_SEVERITY  = 3'd5;

   localparam logic [1:0] FAULT_NONE      = 2'd0;
   localparam logic [1:0] FAULT_IMBALANCE = 2'd1;
   localparam logic [1:0] FAULT_MISALIGN  = 2'd2;
   localparam logic [1:0] FAULT_BEARING   = 2'd3;

   localparam logic [31:0] SEED_DEFAULT   = 32'hA5A5A5A5;
   localparam logic [30:0] ROT_STEP_RESET = 31'd107374182;
   localparam logic [30:0] HUM_STEP_RESET = 31'd773094113;
   localparam logic [15:0] LOAD_RESET     = 16'd42598;
   localparam logic [15:0] GAIN_UNITY     = 16'd32768;
   localparam logic [15:0] GAIN_LOW       = 16'd29491;
   localparam logic [15:0] GAIN_HIGH      = 16'd36045;

   // Q.16 constants, except SPIKE_WINDOW, a Q.32 phase fraction, and SPIKE_RECIP, an integer.
   localparam logic [14:0] COEF_BASE      = 15'd5243;
   localparam int          COEF_0P08      = 5243;
   localparam int          COEF_0P02      = 1311;
   localparam int          COEF_0P01      = 655;
   localparam int          COEF_0P35      = 22938;
   localparam int          COEF_0P20      = 13107;
   localparam int          COEF_0P6       = 39322;
   localparam int          COEF_0P85      = 55706;
   localparam int          COEF_GAIN_SPAN = 6554;
   localparam int          NOISE_OFFSET   = 196608;
   localparam int          SPIKE_WINDOW   = 85899346;
   localparam int          SPIKE_RECIP    = 50;
   localparam logic [16:0] SPIKE_FULL     = 17'd65536;

   function automatic logic [31:0] xorshift32(input logic [31:0] s);
      logic [31:0] x;
      x = s;
      x = x ^ (x << 13);
      x = x ^ (x >> 17);
      x = x ^ (x << 5);
      return x;
   endfunction

   function automatic logic signed [31:0] zext17(input logic [16:0] v);
      return $signed({15'd0, v});
   endfunction

   // Rounds Q.16 to Q3.12 and clamps to the 16-bit output range.
   function automatic logic signed [15:0] sat_out(input logic signed [31:0] v);
      logic signed [31:0] t;
      t = (v + 32'sd8) >>> 4;
      if (t > 32'sd32767) begin
         return 16'sh7FFF;
      end else if (t < -32'sd32768) begin
         return 16'sh8000;
      end
      return t[15:0];
   endfunction

endpackage

/* rtl/vss_req_if.sv */
// ----------------------------------------------------------------------------
// Sample request channel
// Valid/ready channel that carries one sample request with its window flag.
// ----------------------------------------------------------------------------
interface vss_req_if;
   logic valid;
   logic ready;
   logic new_window;

   modport source(output valid, output new_window, input ready);
   modport sink(input valid, input new_window, output ready);
endinterface

/* rtl/vss_rsp_if.sv */
// ----------------------------------------------------------------------------
// Sample result channel
// Valid/ready channel that carries one three-axis acceleration sample.
// ----------------------------------------------------------------------------
interface vss_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] accel_x;
   logic signed [15:0] accel_y;
   logic signed [15:0] accel_z;

   modport source(output valid, output accel_x, output accel_y, output accel_z,
                  input ready);
   modport sink(input valid, input accel_x, input accel_y, input accel_z,
                output ready);
endinterface

/* rtl/vibration_signal_synthesizer.sv */
// ----------------------------------------------------------------------------
// Vibration signal synthesizer
// Makes one synthetic three-axis accelerometer sample per request: tones,
// Gaussian noise, a selectable fault signature and per-axis gains.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Contents
//  req_port  in         new_window
//  rsp_port  out        accel_x, accel_y, accel_z (signed Q3.12)
//  APB       in/out     six registers at byte addresses 0, 4, .. 20
//
// A new window adds three gain draws, and each fault kind adds its own steps
// (bearing wear more inside a spike). All products go through one shared
// 32x32 multiplier under a sequencer; the xorshift generator yields one draw
// per cycle. The result is moved out only once the result register is free,
// and the block is ready again in the next cycle. Reset is synchronous and
// restores configuration, generator, phase, gain and control state but not
// the datapath; the sine table is a constant ROM and needs no fill.
//
module vibration_signal_synthesizer #(
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic         clock,
   input  logic         reset,
   vss_req_if.sink      req_port,
   vss_rsp_if.source    rsp_port,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [4:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);
   import vss_pkg::*;

   localparam int TabN  = 1 << SINE_TABLE_BITS;
   localparam int AddrW = SINE_TABLE_BITS + 1;

   typedef logic [16:0] rom_type [TabN + 1];

   function automatic rom_type build_rom();
      rom_type     r;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] inner;
      logic [63:0] outer;
      logic [63:0] val;
      for (int k = 0; k <= TabN; k++) begin
         x     = 64'(k) << (16 - SINE_TABLE_BITS);
         x2    = (x * x) >> 16;
         inner = 64'd42048 - ((x2 * 64'd4640) >> 16);
         outer = 64'd102944 - ((x2 * inner) >> 16);
         val   = (x * outer) >> 16;
         if (val > 64'd65536) begin
            val = 64'd65536;
         end
         r[k] = val[16:0];
      end
      return r;
   endfunction

   localparam rom_type SineRom = build_rom();

   // Configuration registers.
   logic [31:0] seed_ff, seed_in;
   logic [30:0] rot_step_ff, rot_step_in;
   logic [30:0] hum_step_ff, hum_step_in;
   logic [15:0] load_ff, load_in;
   logic [1:0]  fault_ff, fault_in;
   logic [15:0] sev_ff, sev_in;

   // Generator and phase state.
   logic [31:0] rng_ff, rng_in;
   logic [31:0] rot_ff, rot_in;
   logic [31:0] hum_ff, hum_in;
   logic [15:0] gain_ff [3];
   logic [15:0] gain_in [3];

   // Sequencer and datapath.
   state_type          state_ff, state_in;
   gctx_type           gctx_ff, gctx_in;
   logic signed [31:0] acc_ff, acc_in;
   logic signed [31:0] vax_ff, vax_in;
   logic signed [63:0] prod_ff, prod_in;
   logic [15:0]        coef_ff, coef_in;
   logic [18:0]        sum_ff, sum_in;
   logic [2:0]         ucnt_ff, ucnt_in;
   logic [1:0]         idx_ff, idx_in;
   logic [16:0]        spk_ff, spk_in;
   logic [16:0]        rom_ff;
   logic               neg_ff;
   logic signed [15:0] res_ff [3];
   logic signed [15:0] res_in [3];

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_x_ff, rsp_x_in;
   logic signed [15:0] rsp_y_ff, rsp_y_in;
   logic signed [15:0] rsp_z_ff, rsp_z_in;

   logic [31:0]        ph_sel;
   logic [SINE_TABLE_BITS-1:0] tab_idx;
   logic [AddrW-1:0]   rom_addr;
   logic signed [31:0] mul_a, mul_b;
   logic               mul_en;
   logic signed [31:0] sin_s;
   logic signed [31:0] prod_sh16;
   logic signed [31:0] prod_sh15;
   logic [31:0]        rng_next;
   logic [31:0]        rot2, rot3, rot5;
   logic [14:0]        base;
   logic [14:0]        base4;
   logic               apb_wr;
   logic               quot_high;

   assign pready         = 1'b1;
   assign apb_wr         = psel && penable && pwrite;
   assign req_port.ready = (state_ff == ST_IDLE);
   assign rsp_port.valid   = rsp_valid_ff;
   assign rsp_port.accel_x = rsp_x_ff;
   assign rsp_port.accel_y = rsp_y_ff;
   assign rsp_port.accel_z = rsp_z_ff;

   assign rng_next  = xorshift32(rng_ff);
   assign rot2      = {rot_ff[30:0], 1'b0};
   assign rot3      = rot_ff + rot2;
   assign rot5      = rot_ff + {rot_ff[29:0], 2'b00};
   assign base      = 15'(COEF_BASE + 15'(load_ff >> 2));
   assign base4     = base >> 2;
   assign sin_s     = neg_ff ? -zext17(rom_ff) : zext17(rom_ff);
   assign prod_sh16 = 32'(prod_ff >>> 16);
   assign prod_sh15 = 32'(prod_ff >>> 15);
   assign quot_high = prod_ff[47:0] > {5'd0, rot5[26:0], 16'd0};

   // Quarter-wave lookup: odd quadrants run the table backward.
   assign tab_idx  = ph_sel[29 -: SINE_TABLE_BITS];
   assign rom_addr = ph_sel[30] ? AddrW'(TabN) - {1'b0, tab_idx} : {1'b0, tab_idx};

   always_comb begin
      unique case (paddr[4:2])
         REG_SEED:     prdata = seed_ff;
         REG_ROT_STEP: prdata = {1'b0, rot_step_ff};
         REG_HUM_STEP: prdata = {1'b0, hum_step_ff};
         REG_LOAD:     prdata = {16'd0, load_ff};
         REG_FAULT:    prdata = {30'd0, fault_ff};
         REG_SEVERITY: prdata = {16'd0, sev_ff};
         default:      prdata = '0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      gctx_in      = gctx_ff;
      acc_in       = acc_ff;
      vax_in       = vax_ff;
      prod_in      = prod_ff;
      coef_in      = coef_ff;
      sum_in       = sum_ff;
      ucnt_in      = ucnt_ff;
      idx_in       = idx_ff;
      spk_in       = spk_ff;
      rng_in       = rng_ff;
      rot_in       = rot_ff;
      hum_in       = hum_ff;
      gain_in      = gain_ff;
      res_in       = res_ff;
      seed_in      = seed_ff;
      rot_step_in  = rot_step_ff;
      hum_step_in  = hum_step_ff;
      load_in      = load_ff;
      fault_in     = fault_ff;
      sev_in       = sev_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_port.ready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_z_in     = rsp_z_ff;
      ph_sel       = rot_ff;
      mul_a        = '0;
      mul_b        = '0;
      mul_en       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_port.valid) begin
               idx_in = '0;
               if (req_port.new_window) begin
                  rng_in   = rng_next;
                  state_in = ST_GAIN_MUL;
               end else begin
                  state_in = ST_SIN_R;
               end
            end
         end
         ST_GAIN_MUL: begin
            mul_a    = 32'(COEF_GAIN_SPAN);
            mul_b    = $signed({16'd0, rng_ff[31:16]});
            mul_en   = 1'b1;
            state_in = ST_GAIN_WR;
         end
         ST_GAIN_WR: begin
            gain_in[idx_ff] = GAIN_LOW + {3'd0, prod_ff[28:16]};
            if (idx_ff == 2'd2) begin
               state_in = ST_SIN_R;
            end else begin
               rng_in   = rng_next;
               idx_in   = idx_ff + 2'd1;
               state_in = ST_GAIN_MUL;
            end
         end
         ST_SIN_R: begin
            acc_in   = '0;
            state_in = ST_MUL_R;
         end
         ST_MUL_R: begin
            ph_sel   = rot2;
            mul_a    = $signed({17'd0, base});
            mul_b    = sin_s;
            mul_en   = 1'b1;
            state_in = ST_MUL_R2;
         end
         ST_MUL_R2: begin
            ph_sel   = hum_ff;
            acc_in   = acc_ff + prod_sh16;
            mul_a    = $signed({17'd0, base4});
            mul_b    = sin_s;
            mul_en   = 1'b1;
            state_in = ST_MUL_H;
         end
         ST_MUL_H: begin
            acc_in   = acc_ff + prod_sh16;
            mul_a    = 32'(COEF_0P02);
            mul_b    = sin_s;
            mul_en   = 1'b1;
            state_in = ST_ADD_H;
         end
         ST_ADD_H: begin
            acc_in   = acc_ff + prod_sh16;
            mul_a    = 32'(COEF_0P01);
            mul_b    = $signed({16'd0, load_ff});
            mul_en   = 1'b1;
            state_in = ST_STD;
         end
         ST_STD: begin
            coef_in  = 16'(COEF_0P02) + prod_ff[31:16];
            gctx_in  = GCTX_SAMPLE;
            sum_in   = '0;
            ucnt_in  = '0;
            state_in = ST_N_DRAW;
         end
         ST_N_DRAW: begin
            // Six uniforms, one generator step each.
            rng_in  = rng_next;
            sum_in  = sum_ff + {3'd0, rng_next[31:16]};
            ucnt_in = ucnt_ff + 3'd1;
            if (ucnt_ff == 3'd5) begin
               state_in = ST_N_MUL;
            end
         end
         ST_N_MUL: begin
            mul_a    = $signed({16'd0, coef_ff});
            mul_b    = $signed({13'd0, sum_ff}) - 32'sd196608;
            mul_en   = 1'b1;
            state_in = ST_N_ADD;
         end
         ST_N_ADD: begin
            case (gctx_ff)
               GCTX_SAMPLE: begin
                  acc_in   = acc_ff + prod_sh16;
                  state_in = ST_F_START;
               end
               GCTX_BEAR: begin
                  acc_in   = acc_ff + prod_sh16;
                  idx_in   = '0;
                  state_in = ST_X_START;
               end
               default: begin
                  vax_in   = vax_ff + prod_sh16;
                  state_in = ST_X_OUT;
               end
            endcase
         end
         ST_F_START: begin
            idx_in = '0;
            case (fault_ff)
               FAULT_IMBALANCE: begin
                  mul_a    = 32'(COEF_0P35);
                  mul_b    = $signed({16'd0, sev_ff});
                  mul_en   = 1'b1;
                  state_in = ST_F_IMB_MUL;
               end
               FAULT_MISALIGN: begin
                  ph_sel   = rot2;
                  mul_a    = 32'(COEF_0P20);
                  mul_b    = $signed({16'd0, sev_ff});
                  mul_en   = 1'b1;
                  state_in = ST_F_MIS_MUL2;
               end
               FAULT_BEARING: begin
                  if (rot5 < 32'(SPIKE_WINDOW)) begin
                     // Spike position: quotient from a reciprocal, fixed below.
                     mul_a    = $signed({5'd0, rot5[26:0]});
                     mul_b    = 32'(SPIKE_RECIP);
                     mul_en   = 1'b1;
                     state_in = ST_F_B_QUOT;
                  end else begin
                     state_in = ST_F_BN_COEF;
                  end
               end
               default: begin
                  state_in = ST_X_START;
               end
            endcase
         end
         ST_F_IMB_MUL: begin
            mul_a    = $signed({16'd0, prod_ff[31:16]});
            mul_b    = sin_s;
            mul_en   = 1'b1;
            state_in = ST_F_IMB_ADD;
         end
         ST_F_IMB_ADD: begin
            acc_in   = acc_ff + prod_sh16;
            state_in = ST_X_START;
         end
         ST_F_MIS_MUL2: begin
            ph_sel   = rot3;
            mul_a    = $signed({16'd0, prod_ff[31:16]});
            mul_b    = sin_s;
            mul_en   = 1'b1;
            state_in = ST_F_MIS_ADD2;
         end
         ST_F_MIS_ADD2: begin
            ph_sel   = rot3;
            acc_in   = acc_ff + prod_sh16;
            mul_a    = 32'(COEF_0P08);
            mul_b    = $signed({16'd0, sev_ff});
            mul_en   = 1'b1;
            state_in = ST_F_MIS_MUL3;
         end
         ST_F_MIS_MUL3: begin
            mul_a    = $signed({16'd0, prod_ff[31:16]});
            mul_b    = sin_s;
            mul_en   = 1'b1;
            state_in = ST_F_MIS_ADD3;
         end
         ST_F_MIS_ADD3: begin
            acc_in   = acc_ff + prod_sh16;
            state_in = ST_X_START;
         end
         ST_F_B_QUOT: begin
            coef_in  = prod_ff[31:16];
            mul_a    = $signed({16'd0, prod_ff[31:16]});
            mul_b    = 32'(SPIKE_WINDOW);
            mul_en   = 1'b1;
            state_in = ST_F_B_FIX;
         end
         ST_F_B_FIX: begin
            // The reciprocal estimate is high by at most one.
            spk_in   = SPIKE_FULL - {1'b0, coef_ff} + {16'd0, quot_high};
            mul_a    = 32'(COEF_0P6);
            mul_b    = $signed({16'd0, sev_ff});
            mul_en   = 1'b1;
            state_in = ST_F_B_MUL;
         end
         ST_F_B_MUL: begin
            mul_a    = $signed({16'd0, prod_ff[31:16]});
            mul_b    = zext17(spk_ff);
            mul_en   = 1'b1;
            state_in = ST_F_B_ADD;
         end
         ST_F_B_ADD: begin
            acc_in   = acc_ff + prod_sh16;
            state_in = ST_F_BN_COEF;
         end
         ST_F_BN_COEF: begin
            mul_a    = 32'(COEF_0P08);
            mul_b    = $signed({16'd0, sev_ff});
            mul_en   = 1'b1;
            state_in = ST_F_BN_STD;
         end
         ST_F_BN_STD: begin
            coef_in  = prod_ff[31:16];
            gctx_in  = GCTX_BEAR;
            sum_in   = '0;
            ucnt_in  = '0;
            state_in = ST_N_DRAW;
         end
         ST_X_START: begin
            mul_b  = acc_ff;
            mul_en = 1'b1;
            if (idx_ff == 2'd0) begin
               mul_a    = $signed({16'd0, gain_ff[0]});
               state_in = ST_X_GAIN;
            end else begin
               mul_a    = (idx_ff == 2'd1) ? 32'(COEF_0P85) : 32'(COEF_0P6);
               state_in = ST_X_SCALE;
            end
         end
         ST_X_SCALE: begin
            mul_a    = $signed({16'd0, gain_ff[idx_ff]});
            mul_b    = prod_sh16;
            mul_en   = 1'b1;
            state_in = ST_X_GAIN;
         end
         ST_X_GAIN: begin
            vax_in   = prod_sh15;
            coef_in  = 16'(COEF_0P01);
            gctx_in  = GCTX_AXIS;
            sum_in   = '0;
            ucnt_in  = '0;
            state_in = ST_N_DRAW;
         end
         ST_X_OUT: begin
            res_in[idx_ff] = sat_out(vax_ff);
            if (idx_ff == 2'd2) begin
               state_in = ST_DONE;
            end else begin
               idx_in   = idx_ff + 2'd1;
               state_in = ST_X_START;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_port.ready) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = res_ff[0];
               rsp_y_in     = res_ff[1];
               rsp_z_in     = res_ff[2];
               rot_in       = rot_ff + {1'b0, rot_step_ff};
               hum_in       = hum_ff + {1'b0, hum_step_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (mul_en) begin
         prod_in = mul_a * mul_b;
      end

      if (apb_wr) begin
         unique case (paddr[4:2])
            REG_SEED: begin
               seed_in = pwdata;
               rng_in  = (pwdata != '0) ? pwdata : SEED_DEFAULT;
            end
            REG_ROT_STEP: rot_step_in = pwdata[30:0];
            REG_HUM_STEP: hum_step_in = pwdata[30:0];
            REG_LOAD:     load_in     = pwdata[15:0];
            REG_FAULT:    fault_in    = pwdata[1:0];
            REG_SEVERITY: sev_in      = pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         seed_ff      <= SEED_DEFAULT;
         rot_step_ff  <= ROT_STEP_RESET;
         hum_step_ff  <= HUM_STEP_RESET;
         load_ff      <= LOAD_RESET;
         fault_ff     <= FAULT_NONE;
         sev_ff       <= '0;
         rng_ff       <= SEED_DEFAULT;
         rot_ff       <= '0;
         hum_ff       <= '0;
         gain_ff[0]   <= GAIN_UNITY;
         gain_ff[1]   <= GAIN_UNITY;
         gain_ff[2]   <= GAIN_UNITY;
         gctx_ff      <= GCTX_SAMPLE;
         idx_ff       <= '0;
         ucnt_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         seed_ff      <= seed_in;
         rot_step_ff  <= rot_step_in;
         hum_step_ff  <= hum_step_in;
         load_ff      <= load_in;
         fault_ff     <= fault_in;
         sev_ff       <= sev_in;
         rng_ff       <= rng_in;
         rot_ff       <= rot_in;
         hum_ff       <= hum_in;
         gain_ff      <= gain_in;
         gctx_ff      <= gctx_in;
         idx_ff       <= idx_in;
         ucnt_ff      <= ucnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      vax_ff   <= vax_in;
      prod_ff  <= prod_in;
      coef_ff  <= coef_in;
      sum_ff   <= sum_in;
      spk_ff   <= spk_in;
      res_ff   <= res_in;
      rsp_x_ff <= rsp_x_in;
      rsp_y_ff <= rsp_y_in;
      rsp_z_ff <= rsp_z_in;
      rom_ff   <= SineRom[rom_addr];
      neg_ff   <= ph_sel[31];
   end

`ifndef SYNTHESIS
   a_rng_nonzero: assert property (@(posedge clock) disable iff (reset)
      rng_ff != '0)
      else $error("generator state reached zero");

   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      (gain_ff[0] >= GAIN_LOW) && (gain_ff[0] < GAIN_HIGH) &&
      (gain_ff[1] >= GAIN_LOW) && (gain_ff[1] < GAIN_HIGH) &&
      (gain_ff[2] >= GAIN_LOW) && (gain_ff[2] < GAIN_HIGH))
      else $error("axis gain outside its drawn range");

   a_done_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_port.ready)
      |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("finished sample not presented on the result channel");
`endif

endmodule

/* tb/sv/vibration_signal_synthesizer_test.sv */
// ----------------------------------------------------------------------------
// Vibration signal synthesizer testbench
// Sends sample requests through directed rows and random traffic, writes the
// registers over APB between phases, and checks every result against an
// in-bench fixed-point model of the synthesizer.
// ----------------------------------------------------------------------------
module vibration_signal_synthesizer_test;
   import vss_pkg::*;

   localparam int QUARTER = 1024;
   localparam int LIMIT_CYCLES = 3000000;

   typedef struct packed {
      logic signed [15:0] ax;
      logic signed [15:0] ay;
      logic signed [15:0] az;
   } accel_type;

   typedef struct {
      logic       win;
      logic       typed;
      accel_type  want;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [4:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   vss_req_if req_ch();
   vss_rsp_if rsp_ch();

   vibration_signal_synthesizer uut (
      .clock(clock), .reset(reset), .req_port(req_ch.sink), .rsp_port(rsp_ch.source),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // Predictor copy of the registers and running state.
   longint sine_rom [0:QUARTER];
   logic [31:0] m_rand, m_rot, m_hum, m_rot_step, m_hum_step;
   logic [15:0] m_load, m_sev, m_gx, m_gy, m_gz;
   logic [1:0]  m_fault;

   accel_type expected_samples[$];
   int        cycle_count;
   int        mismatches;
   int        stall_left;

   initial clock = 1'b0;
   always #4 clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // Floor-rounding arithmetic shift, as the datapath does it.
   function automatic longint floor_shift(longint v, int n);
      return v >>> n;
   endfunction

   function automatic logic [31:0] draw_random();
      m_rand = m_rand ^ (m_rand << 13);
      m_rand = m_rand ^ (m_rand >> 17);
      m_rand = m_rand ^ (m_rand << 5);
      return m_rand;
   endfunction

   function automatic longint gaussian(longint stdq);
      longint s;
      logic [31:0] r;
      s = 0;
      for (int i = 0; i < 6; i++) begin
         r = draw_random();
         s += longint'(r[31:16]);
      end
      return floor_shift(stdq * (s - 196608), 16);
   endfunction

   function automatic logic [15:0] gain_draw();
      logic [31:0] r;
      r = draw_random();
      return 16'(29491 + ((6554 * longint'(r[31:16])) >> 16));
   endfunction

   function automatic longint sine_of(logic [31:0] ph);
      int idx;
      longint v;
      idx = int'(ph[29:20]);
      if (ph[30]) idx = QUARTER - idx;
      v = sine_rom[idx];
      return ph[31] ? -v : v;
   endfunction

   function automatic logic signed [15:0] to_q312(longint v);
      longint t;
      t = floor_shift(v + 8, 4);
      if (t > 32767) t = 32767;
      if (t < -32768) t = -32768;
      return 16'(t);
   endfunction

   function automatic accel_type synthesize(logic win);
      longint ld, sv, base, smp, flt, vx, vy, vz, spike;
      logic [31:0] r, p;
      accel_type a;
      ld = longint'(m_load);
      sv = longint'(m_sev);
      r = m_rot;
      flt = 0;
      if (win) begin
         m_gx = gain_draw();
         m_gy = gain_draw();
         m_gz = gain_draw();
      end
      base = 5243 + (ld >> 2);
      smp = floor_shift(base * sine_of(r), 16)
          + floor_shift((base >> 2) * sine_of(r * 2), 16)
          + floor_shift(1311 * sine_of(m_hum), 16);
      smp += gaussian(1311 + ((655 * ld) >> 16));
      case (m_fault)
         FAULT_IMBALANCE: flt = floor_shift(((22938 * sv) >> 16) * sine_of(r), 16);
         FAULT_MISALIGN: begin
            flt = floor_shift(((13107 * sv) >> 16) * sine_of(r * 2), 16)
                + floor_shift(((5243 * sv) >> 16) * sine_of(r * 3), 16);
         end
         FAULT_BEARING: begin
            p = r * 5;
            if (p < 32'd85899346) begin
               spike = 65536 - ((longint'(p) * 65536) / 85899346);
               flt = floor_shift(((39322 * sv) >> 16) * spike, 16);
            end
            flt += gaussian((5243 * sv) >> 16);
         end
         default: flt = 0;
      endcase
      smp += flt;
      vx = floor_shift(longint'(m_gx) * smp, 15) + gaussian(655);
      vy = floor_shift(longint'(m_gy) * floor_shift(55706 * smp, 16), 15) + gaussian(655);
      vz = floor_shift(longint'(m_gz) * floor_shift(39322 * smp, 16), 15) + gaussian(655);
      m_rot = m_rot + m_rot_step;
      m_hum = m_hum + m_hum_step;
      a.ax = to_q312(vx);
      a.ay = to_q312(vy);
      a.az = to_q312(vz);
      return a;
   endfunction

   task automatic model_reset();
      longint x, x2, inner, outer, val;
      for (int k = 0; k <= QUARTER; k++) begin
         x = longint'(k) << 6;
         x2 = (x * x) >> 16;
         inner = 42048 - ((x2 * 4640) >> 16);
         outer = 102944 - ((x2 * inner) >> 16);
         val = (x * outer) >> 16;
         if (val > 65536) val = 65536;
         sine_rom[k] = val;
      end
      m_rand = SEED_DEFAULT;
      m_rot_step = 32'(ROT_STEP_RESET);
      m_hum_step = 32'(HUM_STEP_RESET);
      m_load = LOAD_RESET;
      m_fault = FAULT_NONE;
      m_sev = 16'd0;
      m_rot = 0;
      m_hum = 0;
      m_gx = GAIN_UNITY;
      m_gy = GAIN_UNITY;
      m_gz = GAIN_UNITY;
   endtask

   task automatic write_register(logic [2:0] index, logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (index)
         REG_SEED: m_rand = (value == 0) ? SEED_DEFAULT : value;
         REG_ROT_STEP: m_rot_step = {1'b0, value[30:0]};
         REG_HUM_STEP: m_hum_step = {1'b0, value[30:0]};
         REG_LOAD: m_load = value[15:0];
         REG_FAULT: m_fault = value[1:0];
         REG_SEVERITY: m_sev = value[15:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic random_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) n = 0;
      repeat (n) @(posedge clock);
   endtask

   task automatic send_request(logic win);
      req_ch.valid <= 1'b1;
      req_ch.new_window <= win;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      req_ch.valid <= 1'b0;
      expected_samples.push_back(synthesize(win));
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   // Directed rows: every sample carries generator noise, so no row has a
   // value typed in and all rows go through the predictor.
   task automatic run_directed();
      stim_row_type rows [8];
      for (int i = 0; i < 8; i++) begin
         rows[i].win = 1'(i % 2);
         rows[i].typed = 1'b0;
         rows[i].want = '0;
      end
      rows[0].win = 1'b0;
      foreach (rows[i]) begin
         send_request(rows[i].win);
         if (rows[i].typed && expected_samples[$] != rows[i].want) begin
            mismatches++;
            $display("directed row %0d: table value disagrees", i);
         end
      end
      wait_drained();
   endtask

   // Result side: random stalls and the field-by-field comparison.
   always @(posedge clock) begin
      accel_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_samples.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected transaction x=%0d y=%0d z=%0d",
                  rsp_ch.accel_x, rsp_ch.accel_y, rsp_ch.accel_z);
            end else begin
               want = expected_samples.pop_front();
               if (want.ax !== rsp_ch.accel_x || want.ay !== rsp_ch.accel_y ||
                   want.az !== rsp_ch.accel_z) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("sample mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                        want.ax, want.ay, want.az,
                        rsp_ch.accel_x, rsp_ch.accel_y, rsp_ch.accel_z);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_ch.ready <= 1'b0;
         end else if ($urandom_range(0, 15) == 0) begin
            stall_left <= ($urandom_range(0, 9) == 0) ?
               $urandom_range(10, 80) : $urandom_range(0, 3);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count > LIMIT_CYCLES) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      logic [31:0] extremes [4];
      cycle_count = 0;
      mismatches = 0;
      reset <= 1'b1;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      req_ch.valid <= 1'b0;
      req_ch.new_window <= 1'b0;
      model_reset();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      // Extreme register settings, each fault kind.
      write_register(REG_SEED, 32'd0);
      write_register(REG_LOAD, 32'hFFFF);
      write_register(REG_SEVERITY, 32'hFFFF);
      write_register(REG_ROT_STEP, 32'h7FFFFFFF);
      write_register(REG_HUM_STEP, 32'h7FFFFFFF);
      for (int f = 0; f < 4; f++) begin
         write_register(REG_FAULT, 32'(f));
         for (int i = 0; i < 5; i++) send_request(1'(i == 0));
         wait_drained();
      end
      write_register(REG_LOAD, 32'd0);
      write_register(REG_SEVERITY, 32'd0);
      write_register(REG_ROT_STEP, 32'd0);
      write_register(REG_HUM_STEP, 32'd0);
      write_register(REG_SEED, 32'hFFFFFFFF);
      for (int i = 0; i < 4; i++) send_request(1'b1);
      wait_drained();

      // Random phases with random register settings.
      extremes = '{32'd0, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'd1};
      for (int ph = 0; ph < 18; ph++) begin
         write_register(REG_SEED, $urandom());
         write_register(REG_ROT_STEP, ($urandom_range(0, 4) == 0) ?
            extremes[$urandom_range(0, 3)] : $urandom_range(0, 32'h0FFFFFFF));
         write_register(REG_HUM_STEP, $urandom());
         write_register(REG_LOAD, ($urandom_range(0, 4) == 0) ?
            extremes[$urandom_range(0, 3)] : $urandom());
         write_register(REG_FAULT, $urandom_range(0, 3));
         write_register(REG_SEVERITY, $urandom());
         for (int i = 0; i < 100; i++) begin
            random_gap();
            send_request(1'($urandom_range(0, 7) == 0));
            // Hold off once until the pipeline has emptied.
            if (ph == 3 && i == 50)
               while (expected_samples.size() != 0) @(posedge clock);
         end
         wait_drained();
      end

      if (mismatches == 0 && expected_samples.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/vss_pkg.sv
rtl/vss_req_if.sv
rtl/vss_rsp_if.sv
rtl/vibration_signal_synthesizer.sv
tb/sv/vibration_signal_synthesizer_test.sv
